// ===== hw/rtl/layer_blit_overlap_planner_defines.svh =====
// Assertion macros for the blit overlap planner.
// Define NO_ASSERTIONS to compile them out.
`ifndef LAYER_BLIT_OVERLAP_PLANNER_DEFINES_SVH
`define LAYER_BLIT_OVERLAP_PLANNER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LBOP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBOP_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBOP_ASSERT(label, clk, rst_n, prop, msg)
`define LBOP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/lbop_pkg.sv =====
// Shared types and constants for the blit overlap planner.
// Used by the interfaces, the controller, the datapath and the top level.
package lbop_pkg;
  localparam int LIST_DEPTH = 64;
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int COORD_BITS = 16;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ADD_SRC = 2'd1,
    MODE_ADD_DST = 2'd2,
    MODE_RUN = 2'd3
  } mode_t;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } rect_t;

  typedef struct packed {
    logic [7:0] bm;
    rect_t r;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [7:0] bitmap_id;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [5:0] source_index;
  } in_item_t;

  typedef struct packed {
    logic valid_res;
    logic [7:0] src_bitmap;
    logic signed [15:0] src_x0;
    logic signed [15:0] src_y0;
    logic signed [15:0] src_x1;
    logic signed [15:0] src_y1;
    logic [7:0] dst_bitmap;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the input beat
    logic start;       // latch displacement
    logic rd;          // read the list at rd_addr (registered)
    logic sel_dst;     // which list rd/wr address
    logic [IDX_W-1:0] rd_addr;
    logic cmp;         // evaluate ordering on the read data
    logic wr_shift;    // write read data one place up
    logic wr_new;      // write the new piece
    logic [IDX_W-1:0] wr_addr;
    logic load_src;    // capture the read data as the run source
    logic emit;        // form a result from the read data into the out stage
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic ahead;       // read entry stays ahead of the new piece
  } dp_stat_t;

  // Sign extension of a COORD_BITS field to 16 bits.
  function automatic logic [15:0] cx(input logic [15:0] v);
    logic [15:0] m;
    m = v;
    if (COORD_BITS < 16) begin
      for (int i = 0; i < 16; i++) begin
        if (i >= COORD_BITS) m[i] = v[COORD_BITS-1];
      end
    end
    return m;
  endfunction
endpackage

// ===== hw/rtl/lbop_item_if.sv =====
// Valid/ready channel for planner input beats.
// Depends on lbop_pkg.
interface lbop_item_if;
  logic valid;
  logic ready;
  lbop_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lbop_res_if.sv =====
// Valid/ready channel for planner result beats.
// Depends on lbop_pkg.
interface lbop_res_if;
  logic valid;
  logic ready;
  lbop_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lbop_datapath.sv =====
// Datapath of the planner: piece lists, ordering test, clip and result stage.
// Depends on lbop_pkg and the assertion macros header.
`include "layer_blit_overlap_planner_defines.svh"
module lbop_datapath (
  input  logic clk,
  input  logic rst_n,
  input  lbop_pkg::in_item_t item,
  input  lbop_pkg::dp_cmd_t cmd,
  output lbop_pkg::dp_stat_t stat,
  output lbop_pkg::out_item_t res,
  output logic res_valid,
  input  logic res_ready
);
  // The two piece lists, one memory each.
  lbop_pkg::entry_t src_mem [lbop_pkg::LIST_DEPTH];
  lbop_pkg::entry_t dst_mem [lbop_pkg::LIST_DEPTH];
  lbop_pkg::entry_t src_q_r, dst_q_r, rd_q;
  lbop_pkg::in_item_t item_r;
  logic [15:0] disp_x_r, disp_y_r;
  lbop_pkg::entry_t srce_r;
  lbop_pkg::out_item_t res_r;
  logic res_valid_r;
  logic ahead_r;
  lbop_pkg::entry_t new_e, wr_data;

  assign new_e = '{bm: item_r.bitmap_id,
                   r: '{x0: lbop_pkg::cx(item_r.x0), y0: lbop_pkg::cx(item_r.y0),
                        x1: lbop_pkg::cx(item_r.x1), y1: lbop_pkg::cx(item_r.y1)}};
  assign wr_data = cmd.wr_new ? new_e : rd_q;
  assign rd_q = cmd.sel_dst ? dst_q_r : src_q_r;

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.wr_new || cmd.wr_shift) begin
      if (cmd.sel_dst) dst_mem[cmd.wr_addr] <= wr_data;
      else src_mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      src_q_r <= src_mem[cmd.rd_addr];
      dst_q_r <= dst_mem[cmd.rd_addr];
    end
  end

  // Input capture, displacement and run source.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_x_r <= '0;
      disp_y_r <= '0;
    end else if (cmd.start) begin
      disp_x_r <= lbop_pkg::cx(item_r.delta_x);
      disp_y_r <= lbop_pkg::cx(item_r.delta_y);
    end
    if (cmd.load_item) item_r <= item;
    if (cmd.load_src) srce_r <= src_q_r;
  end

  // Ordering test: only the signs of the factors matter, so no multiplier.
  logic ovl;
  logic signed [16:0] dd;
  logic signed [15:0] dsp;
  logic ahead_nxt;
  always_comb begin
    ovl = ($signed(rd_q.r.y0) < $signed(new_e.r.y1)) &&
          ($signed(new_e.r.y0) < $signed(rd_q.r.y1));
    if (ovl) begin
      dd = $signed({rd_q.r.x0[15], rd_q.r.x0}) - $signed({new_e.r.x0[15], new_e.r.x0});
      dsp = $signed(disp_x_r);
    end else begin
      dd = $signed({rd_q.r.y0[15], rd_q.r.y0}) - $signed({new_e.r.y0[15], new_e.r.y0});
      dsp = $signed(disp_y_r);
    end
    ahead_nxt = (dd == 17'sd0) || (dsp == 16'sd0) || (dd[16] == dsp[15]);
  end
  always_ff @(posedge clk) begin
    if (cmd.cmp) ahead_r <= ahead_nxt;
  end
  assign stat.ahead = ahead_r;

  // Clip in 18-bit arithmetic, then wrap to the coordinate width.
  function automatic logic signed [17:0] sx(input logic [15:0] v);
    return {{2{v[15]}}, v};
  endfunction
  logic signed [17:0] rx0, ry0, rx1, ry1;
  lbop_pkg::out_item_t res_nxt;
  always_comb begin
    rx0 = sx(srce_r.r.x0) + sx(disp_x_r);
    ry0 = sx(srce_r.r.y0) + sx(disp_y_r);
    rx1 = sx(srce_r.r.x1) + sx(disp_x_r);
    ry1 = sx(srce_r.r.y1) + sx(disp_y_r);
    if (sx(dst_q_r.r.x0) > rx0) rx0 = sx(dst_q_r.r.x0);
    if (sx(dst_q_r.r.y0) > ry0) ry0 = sx(dst_q_r.r.y0);
    if (sx(dst_q_r.r.x1) < rx1) rx1 = sx(dst_q_r.r.x1);
    if (sx(dst_q_r.r.y1) < ry1) ry1 = sx(dst_q_r.r.y1);
    res_nxt = '0;
    res_nxt.src_bitmap = srce_r.bm;
    res_nxt.dst_bitmap = dst_q_r.bm;
    res_nxt.last = cmd.emit_last;
    if (rx0 < rx1 && ry0 < ry1) begin
      res_nxt.valid_res = 1'b1;
      res_nxt.src_x0 = lbop_pkg::cx(16'(rx0 - sx(disp_x_r)));
      res_nxt.src_y0 = lbop_pkg::cx(16'(ry0 - sx(disp_y_r)));
      res_nxt.src_x1 = lbop_pkg::cx(16'(rx1 - sx(disp_x_r)));
      res_nxt.src_y1 = lbop_pkg::cx(16'(ry1 - sx(disp_y_r)));
      res_nxt.dst_x = lbop_pkg::cx(16'(rx0));
      res_nxt.dst_y = lbop_pkg::cx(16'(ry0));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else if (cmd.emit) res_valid_r <= 1'b1;
    else if (res_ready) res_valid_r <= 1'b0;
    if (cmd.emit) res_r <= res_nxt;
  end
  assign res = res_r;
  assign res_valid = res_valid_r;

  `LBOP_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> (!res_valid_r || res_ready), "result overwritten")
  `LBOP_ASSERT(a_wr_excl, clk, rst_n, !(cmd.wr_new && cmd.wr_shift), "two writes at once")
  `LBOP_ASSERT(a_emit_held, clk, rst_n, (res_valid_r && !res_ready) |=> $stable(res_r), "result changed while stalled")
endmodule

// ===== hw/rtl/lbop_ctrl.sv =====
// Controller of the planner: sequences insertion scans, shifts and run walks.
// Depends on lbop_pkg and the assertion macros header.
`include "layer_blit_overlap_planner_defines.svh"
module lbop_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  lbop_pkg::in_item_t item,
  input  lbop_pkg::dp_stat_t stat,
  input  logic res_valid,
  input  logic res_ready,
  output lbop_pkg::dp_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_CMP   = 8'b00001000,
    S_SHIFT = 8'b00010000,
    S_INS   = 8'b00100000,
    S_RSRC  = 8'b01000000,
    S_RUN   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [lbop_pkg::CNT_W-1:0] src_cnt_r, src_cnt_nxt, dst_cnt_r, dst_cnt_nxt;
  logic [lbop_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [5:0] sidx_r, sidx_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic [lbop_pkg::CNT_W-1:0] cnt_sel;

  assign cnt_sel = (mode_r == lbop_pkg::MODE_ADD_DST) ? dst_cnt_r : src_cnt_r;
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      ptr_r <= '0;
      mode_r <= '0;
      sidx_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      src_cnt_r <= src_cnt_nxt;
      dst_cnt_r <= dst_cnt_nxt;
      ptr_r <= ptr_nxt;
      mode_r <= mode_nxt;
      sidx_r <= sidx_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Insertion: scan forward from 0 comparing; on the first failure (or the end)
  // shift from the tail down to the slot, then write the new piece.
  // Run: read the source entry, then read each destination entry and emit.
  always_comb begin
    state_nxt = state_r;
    src_cnt_nxt = src_cnt_r;
    dst_cnt_nxt = dst_cnt_r;
    ptr_nxt = ptr_r;
    mode_nxt = mode_r;
    sidx_nxt = sidx_r;
    rd_pend_nxt = 1'b0;
    cmd = '0;
    cmd.sel_dst = (mode_r == lbop_pkg::MODE_ADD_DST) || (mode_r == lbop_pkg::MODE_RUN);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          mode_nxt = item.mode;
          sidx_nxt = item.source_index;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ptr_nxt = '0;
        unique case (mode_r)
          lbop_pkg::MODE_START: begin
            cmd.start = 1'b1;
            src_cnt_nxt = '0;
            dst_cnt_nxt = '0;
            state_nxt = S_IDLE;
          end
          lbop_pkg::MODE_ADD_SRC, lbop_pkg::MODE_ADD_DST: begin
            if (cnt_sel == lbop_pkg::CNT_W'(lbop_pkg::LIST_DEPTH)) state_nxt = S_IDLE;
            else state_nxt = S_SCAN;
          end
          default: begin
            if ({1'b0, sidx_r} >= 7'(src_cnt_r) || dst_cnt_r == '0) state_nxt = S_IDLE;
            else begin
              cmd.rd = 1'b1;
              cmd.rd_addr = sidx_r[lbop_pkg::IDX_W-1:0];
              state_nxt = S_RSRC;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (ptr_r == cnt_sel) begin
          state_nxt = S_INS;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_addr = ptr_r[lbop_pkg::IDX_W-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // Read data is present now; compare registers the verdict.
        cmd.cmp = 1'b1;
        rd_pend_nxt = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (rd_pend_r) begin
          if (stat.ahead) begin
            ptr_nxt = ptr_r + 1'b1;
            state_nxt = S_SCAN;
          end else begin
            // Slot found at ptr_r; shift from the tail with a fresh counter.
            mode_nxt = mode_r;
            sidx_nxt = 6'(cnt_sel);
            state_nxt = (cnt_sel == ptr_r) ? S_INS : S_SHIFT;
            if (cnt_sel != ptr_r) begin
              cmd.rd = 1'b1;
              cmd.rd_addr = lbop_pkg::IDX_W'(cnt_sel - 1'b1);
            end
          end
        end else begin
          // Read data of entry sidx-1 is present; write it to sidx.
          cmd.wr_shift = 1'b1;
          cmd.wr_addr = sidx_r[lbop_pkg::IDX_W-1:0];
          sidx_nxt = sidx_r - 1'b1;
          if (7'(sidx_r) - 7'd1 == 7'(ptr_r)) begin
            state_nxt = S_INS;
          end else begin
            cmd.rd = 1'b1;
            cmd.rd_addr = lbop_pkg::IDX_W'(sidx_r - 6'd2);
          end
        end
      end
      S_INS: begin
        cmd.wr_new = 1'b1;
        cmd.wr_addr = ptr_r[lbop_pkg::IDX_W-1:0];
        if (mode_r == lbop_pkg::MODE_ADD_DST) dst_cnt_nxt = dst_cnt_r + 1'b1;
        else src_cnt_nxt = src_cnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_RSRC: begin
        cmd.load_src = 1'b1;
        cmd.rd = 1'b1;
        cmd.rd_addr = '0;
        ptr_nxt = '0;
        rd_pend_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        rd_pend_nxt = rd_pend_r;
        if (!res_valid || res_ready) begin
          cmd.emit = 1'b1;
          cmd.emit_last = (ptr_r + 1'b1 == dst_cnt_r);
          if (ptr_r + 1'b1 == dst_cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
            cmd.rd = 1'b1;
            cmd.rd_addr = lbop_pkg::IDX_W'(ptr_r + 1'b1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `LBOP_ASSERT(a_src_bound, clk, rst_n, src_cnt_r <= lbop_pkg::CNT_W'(lbop_pkg::LIST_DEPTH), "source count overflow")
  `LBOP_ASSERT(a_dst_bound, clk, rst_n, dst_cnt_r <= lbop_pkg::CNT_W'(lbop_pkg::LIST_DEPTH), "destination count overflow")
  `LBOP_ASSERT(a_run_ptr, clk, rst_n, (state_r == S_RUN) |-> (ptr_r < dst_cnt_r), "run past list end")
  `LBOP_ASSERT_NR(a_reset, clk, !rst_n |=> (state_r == S_IDLE), "not idle after reset")
endmodule

// ===== hw/rtl/layer_blit_overlap_planner.sv =====
// A start beat, and an add to a full list, return to idle after decode. An add
// scans the list comparing, shifts entries from the tail down to the slot, then writes
// the new piece. A run reads the source entry, then shows one result per cycle unless
// the result side stalls. Throughput: one item at a time, paced by the sequential
// scan, shift and walk over the lists; input is ready only when idle.
// Reset: synchronous active-low rst_n empties both lists and clears disp and raster_op.
module layer_blit_overlap_planner (
  input  logic clk,
  input  logic rst_n,
  lbop_item_if.sink in_ch,
  lbop_res_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_wdata
);
  lbop_pkg::dp_cmd_t cmd;
  lbop_pkg::dp_stat_t stat;
  logic res_valid;
  logic [1:0] raster_op_r;

  // Raster function register, written when cfg_we is set.
  always_ff @(posedge clk) begin
    if (!rst_n) raster_op_r <= '0;
    else if (cfg_we) raster_op_r <= cfg_wdata;
  end

  lbop_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .item(in_ch.data),
    .stat, .res_valid, .res_ready(out_ch.ready), .cmd
  );

  lbop_datapath u_dp (
    .clk, .rst_n, .item(in_ch.data), .cmd, .stat,
    .res(out_ch.data), .res_valid, .res_ready(out_ch.ready)
  );
  assign out_ch.valid = res_valid;
endmodule
